@@ hw/rtl/ssxy_pkg.sv @@
// shared constants and types for the square spiral index to coordinate block
// no dependencies
`default_nettype none

package ssxy_pkg;

  localparam int INDEX_BITS  = 31;
  localparam int ROOT_BITS   = (INDEX_BITS + 1) / 2;
  localparam int PAD_BITS    = 2 * ROOT_BITS;
  localparam int REM_BITS    = ROOT_BITS + 2;
  localparam int DIFF_BITS   = ROOT_BITS + 3;
  localparam int COORD_BITS  = 18;
  localparam int WORK_BITS   = COORD_BITS + 1;
  localparam int STAGES      = ROOT_BITS;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [ROOT_BITS:0]            r_near;
    logic signed [DIFF_BITS-1:0]   diff;
  } spiral_job_t;

endpackage

`default_nettype wire

@@ hw/rtl/ssxy_front.sv @@
// front end: accepts index beats, pipelined exact square root, rounding to nearest
// depends on ssxy_pkg
`default_nettype none

module ssxy_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                stall_o,
  input  logic [ssxy_pkg::INDEX_BITS-1:0]     point_index_i,
  input  logic                                q_full_i,
  output logic                                push_o,
  output ssxy_pkg::spiral_job_t               push_job_o
);

  localparam int STAGES    = ssxy_pkg::STAGES;
  localparam int PAD_BITS  = ssxy_pkg::PAD_BITS;
  localparam int REM_BITS  = ssxy_pkg::REM_BITS;
  localparam int ROOT_BITS = ssxy_pkg::ROOT_BITS;
  localparam int DIFF_BITS = ssxy_pkg::DIFF_BITS;

  logic                 adv;
  logic                 st_valid [STAGES+1];
  logic [PAD_BITS-1:0]  st_n     [STAGES+1];
  logic [REM_BITS-1:0]  st_rem   [STAGES+1];
  logic [ROOT_BITS-1:0] st_root  [STAGES+1];

  assign adv     = !q_full_i;
  assign stall_o = !adv;

  assign st_valid[0] = valid_i;
  assign st_n[0]     = PAD_BITS'(point_index_i);
  assign st_rem[0]   = '0;
  assign st_root[0]  = '0;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [REM_BITS-1:0]  acc;
    logic [REM_BITS-1:0]  trial;
    logic                 ge;
    logic                 valid_q;
    logic [PAD_BITS-1:0]  n_q;
    logic [REM_BITS-1:0]  rem_q;
    logic [ROOT_BITS-1:0] root_q;

    assign acc   = {st_rem[s][REM_BITS-3:0], st_n[s][PAD_BITS-1 -: 2]};
    assign trial = {st_root[s], 2'b01};
    assign ge    = (acc >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q <= 1'b0;
      end else if (adv) begin
        valid_q <= st_valid[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        n_q    <= st_n[s] << 2;
        rem_q  <= ge ? (acc - trial) : acc;
        root_q <= {st_root[s][ROOT_BITS-2:0], ge};
      end
    end

    assign st_valid[s+1] = valid_q;
    assign st_n[s+1]     = n_q;
    assign st_rem[s+1]   = rem_q;
    assign st_root[s+1]  = root_q;
  end

  // round to nearest root, offset from its square
  logic                        round_up;
  logic [REM_BITS-1:0]         root_ext;
  logic signed [DIFF_BITS-1:0] rem_s;
  logic signed [DIFF_BITS-1:0] twice_root;

  assign root_ext   = REM_BITS'(st_root[STAGES]);
  assign round_up   = (st_rem[STAGES] > root_ext);
  assign rem_s      = $signed(DIFF_BITS'(st_rem[STAGES]));
  assign twice_root = $signed(DIFF_BITS'({st_root[STAGES], 1'b0}));

  assign push_o            = adv && st_valid[STAGES];
  assign push_job_o.r_near = (ROOT_BITS+1)'(st_root[STAGES]) + (ROOT_BITS+1)'(round_up);
  assign push_job_o.diff   = round_up ? (rem_s - twice_root - DIFF_BITS'(1)) : rem_s;

endmodule

`default_nettype wire

@@ hw/rtl/ssxy_queue.sv @@
// short job queue between the root pipeline and the coordinate stage
// depends on ssxy_pkg
`default_nettype none

module ssxy_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  ssxy_pkg::spiral_job_t   push_job_i,
  output logic                    full_o,
  input  logic                    pop_i,
  output logic                    valid_o,
  output ssxy_pkg::spiral_job_t   job_o
);

  localparam int DEPTH     = ssxy_pkg::QUEUE_DEPTH;
  localparam int PTR_BITS  = ssxy_pkg::QPTR_BITS;
  localparam int CNT_BITS  = ssxy_pkg::QCNT_BITS;

  ssxy_pkg::spiral_job_t entry_q [DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_BITS-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0]   count_q, count_d;
  logic                  do_pop;

  assign full_o  = (count_q == CNT_BITS'(DEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = entry_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_BITS'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_BITS'(1);
    end
    if (push_i && !do_pop) begin
      count_d = count_q + CNT_BITS'(1);
    end else if (do_pop && !push_i) begin
      count_d = count_q - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ssxy_back.sv @@
// back end: corner point plus offset, registered output beat
// depends on ssxy_pkg
`default_nettype none

module ssxy_back (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   q_valid_i,
  input  ssxy_pkg::spiral_job_t                  q_job_i,
  output logic                                   q_pop_o,
  output logic                                   valid_o,
  input  logic                                   stall_i,
  output logic signed [ssxy_pkg::COORD_BITS-1:0] coord_x_o,
  output logic signed [ssxy_pkg::COORD_BITS-1:0] coord_y_o
);

  localparam int WORK_BITS  = ssxy_pkg::WORK_BITS;
  localparam int COORD_BITS = ssxy_pkg::COORD_BITS;

  logic                        load;
  logic                        odd;
  logic                        neg;
  logic signed [WORK_BITS-1:0] k;
  logic signed [WORK_BITS-1:0] dw;
  logic signed [WORK_BITS-1:0] x_w, y_w;
  logic                        valid_q;
  logic [COORD_BITS-1:0]       x_q, y_q;

  assign load    = q_valid_i && (!valid_q || !stall_i);
  assign q_pop_o = load;

  assign odd = q_job_i.r_near[0];
  assign neg = q_job_i.diff[ssxy_pkg::DIFF_BITS-1];
  assign k   = $signed(WORK_BITS'(q_job_i.r_near >> 1));
  assign dw  = WORK_BITS'(q_job_i.diff);

  always_comb begin
    if (odd) begin
      x_w = neg ? k : (k - dw);
      y_w = neg ? (k + WORK_BITS'(1) + dw) : (k + WORK_BITS'(1));
    end else begin
      x_w = neg ? -k : (dw - k);
      y_w = neg ? (-k - dw) : -k;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= load || (valid_q && stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      x_q <= x_w[COORD_BITS-1:0];
      y_q <= y_w[COORD_BITS-1:0];
    end
  end

  assign valid_o   = valid_q;
  assign coord_x_o = $signed(x_q);
  assign coord_y_o = $signed(y_q);

endmodule

`default_nettype wire

@@ hw/rtl/square_spiral_index_to_xy_core.sv @@
// top level of the square spiral index to (x, y) block
// depends on ssxy_pkg, ssxy_front, ssxy_queue, ssxy_back
//
// input channel: valid_i / stall_o with point_index_i; a beat is taken when
// valid_i is high and stall_o low
// output channel: valid_o / stall_i with signed coord_x_o and coord_y_o, one
// beat out for every beat in, in order
// an input beat passes through the square root pipeline, one root bit per stage,
// then through the queue and the output register
// throughput: one beat per cycle while the output is not stalled
// a stalled output holds its beat; the four-entry queue then fills and stall_o
// rises once it is full, freezing the root pipeline in place
// reset empties the pipeline, queue and output register; no clearing pass
`default_nettype none

module square_spiral_index_to_xy_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  output logic                                   stall_o,
  input  logic [ssxy_pkg::INDEX_BITS-1:0]        point_index_i,
  output logic                                   valid_o,
  input  logic                                   stall_i,
  output logic signed [ssxy_pkg::COORD_BITS-1:0] coord_x_o,
  output logic signed [ssxy_pkg::COORD_BITS-1:0] coord_y_o
);

  logic                  q_full;
  logic                  push;
  ssxy_pkg::spiral_job_t push_job;
  logic                  q_valid;
  logic                  q_pop;
  ssxy_pkg::spiral_job_t q_job;

  ssxy_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (valid_i),
    .stall_o       (stall_o),
    .point_index_i (point_index_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .push_job_o    (push_job)
  );

  ssxy_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .job_o      (q_job)
  );

  ssxy_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_job_i   (q_job),
    .q_pop_o   (q_pop),
    .valid_o   (valid_o),
    .stall_i   (stall_i),
    .coord_x_o (coord_x_o),
    .coord_y_o (coord_y_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/ssxy_chk.sv @@
// port-level checks for square_spiral_index_to_xy_core, bound to the top level
// depends on ssxy_pkg
`default_nettype none

module ssxy_chk (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   valid_i,
  input logic                                   stall_o,
  input logic                                   valid_o,
  input logic                                   stall_i,
  input logic signed [ssxy_pkg::COORD_BITS-1:0] coord_x_o,
  input logic signed [ssxy_pkg::COORD_BITS-1:0] coord_y_o
);

  localparam int MAX_OPEN  = ssxy_pkg::STAGES + ssxy_pkg::QUEUE_DEPTH + 1;
  localparam int OPEN_BITS = $clog2(MAX_OPEN + 2);

  logic                 in_beat, out_beat;
  logic [OPEN_BITS-1:0] open_q;

  assign in_beat  = valid_i && !stall_o;
  assign out_beat = valid_o && !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else if (in_beat && !out_beat) begin
      open_q <= open_q + OPEN_BITS'(1);
    end else if (out_beat && !in_beat) begin
      open_q <= open_q - OPEN_BITS'(1);
    end
  end

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !valid_o)
    else $error("output valid during reset");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(coord_x_o) && $stable(coord_y_o))
    else $error("stalled output beat changed");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat |-> (open_q != '0) || in_beat)
    else $error("output beat with no input beat in flight");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q <= OPEN_BITS'(MAX_OPEN))
    else $error("more beats in flight than the block can hold");

endmodule

bind square_spiral_index_to_xy_core ssxy_chk u_ssxy_chk (.*);

`default_nettype wire

@@ dv/tb_square_spiral_index_to_xy_core.sv @@
// self-checking testbench for square_spiral_index_to_xy_core: directed table, then random
// indices under random idling on both channels; a behavioural predictor gives the expected
// points but for three table rows with fixed ones; depends on ssxy_pkg and the core
`timescale 1ns / 100ps

module tb_square_spiral_index_to_xy_core;

  localparam int INDEX_BITS  = ssxy_pkg::INDEX_BITS;
  localparam int ROOT_BITS   = ssxy_pkg::ROOT_BITS;
  localparam int COORD_BITS  = ssxy_pkg::COORD_BITS;
  localparam int LATENCY     = ROOT_BITS + 2;
  localparam int NUM_RANDOM  = 1500;
  localparam int NUM_TABLE   = 23;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } spiral_point_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] idx;
    logic                  typed;
    spiral_point_t         pt;
  } table_row_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         valid_i;
  logic                         stall_o;
  logic [INDEX_BITS-1:0]        point_index_i;
  logic                         valid_o;
  logic                         stall_i;
  logic signed [COORD_BITS-1:0] coord_x_o;
  logic signed [COORD_BITS-1:0] coord_y_o;

  spiral_point_t expected_points [$];
  table_row_t    index_table [NUM_TABLE];
  int            error_count;
  int            cycle_count;
  bit            calm_phase;

  square_spiral_index_to_xy_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (valid_i),
    .stall_o       (stall_o),
    .point_index_i (point_index_i),
    .valid_o       (valid_o),
    .stall_i       (stall_i),
    .coord_x_o     (coord_x_o),
    .coord_y_o     (coord_y_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic spiral_point_t spiral_point_of(input logic [INDEX_BITS-1:0] idx);
    longint        n;
    longint        r;
    longint        cand;
    longint        k;
    longint        d;
    longint        sgn;
    longint        sx;
    longint        sy;
    spiral_point_t p;
    n = longint'(idx);
    r = 0;
    for (int b = ROOT_BITS; b >= 0; b--) begin
      cand = r | (longint'(1) << b);
      if (cand * cand <= n) r = cand;
    end
    if (n > r * r + r) r = r + 1;
    if (r % 2 != 0) begin
      k   = (r - 1) / 2;
      sx  = k;
      sy  = k + 1;
      sgn = -1;
    end else begin
      k   = r / 2;
      sx  = -k;
      sy  = -k;
      sgn = 1;
    end
    d = n - r * r;
    if (d < 0) sy = sy - sgn * d;
    else sx = sx + sgn * d;
    p.x = sx[COORD_BITS-1:0];
    p.y = sy[COORD_BITS-1:0];
    return p;
  endfunction

  function automatic logic [INDEX_BITS-1:0] random_index();
    longint n;
    longint r;
    int     kind;
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      n = longint'($urandom()) & ((longint'(1) << INDEX_BITS) - 1);
    end else if (kind < 6) begin
      n = $urandom_range(0, 2000);
    end else begin
      r = $urandom_range(1, 46340);
      n = r * r + ($urandom_range(0, 1) ? r : 0) + $urandom_range(0, 2) - 1;
    end
    return n[INDEX_BITS-1:0];
  endfunction

  // called just after the clock rises; returns once the core has taken the beat
  task automatic send_index(input logic [INDEX_BITS-1:0] idx, input logic typed,
                            input spiral_point_t typed_pt);
    int gap;
    gap = calm_phase ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i       <= 1'b1;
    point_index_i <= idx;
    do @(posedge clk_i); while (stall_o);
    expected_points.push_back(typed ? typed_pt : spiral_point_of(idx));
  endtask

  task automatic wait_for_drain();
    while (expected_points.size() != 0) @(posedge clk_i);
  endtask

  // output side: random stall per beat, then compare
  initial begin
    int            wait_cycles;
    spiral_point_t exp_pt;
    stall_i <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      wait_cycles = calm_phase ? 0 : $urandom_range(0, 13);
      if (wait_cycles > 0) begin
        stall_i <= 1'b1;
        repeat (wait_cycles) @(posedge clk_i);
      end
      stall_i <= 1'b0;
      do @(posedge clk_i); while (!valid_o);
      if (expected_points.size() == 0) begin
        $error("unexpected beat: coord_x %0d coord_y %0d", coord_x_o, coord_y_o);
        error_count++;
      end else begin
        exp_pt = expected_points.pop_front();
        if (coord_x_o !== exp_pt.x) begin
          $error("coord_x expected %0d actual %0d", exp_pt.x, coord_x_o);
          error_count++;
        end
        if (coord_y_o !== exp_pt.y) begin
          $error("coord_y expected %0d actual %0d", exp_pt.y, coord_y_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    spiral_point_t none_pt;
    none_pt       = '0;
    error_count   = 0;
    calm_phase    = 1'b0;
    rst_ni        <= 1'b0;
    valid_i       <= 1'b0;
    point_index_i <= '0;

    index_table = '{
      '{31'd0,          1'b1, '{18'sd0, 18'sd0}},
      '{31'd1,          1'b1, '{18'sd0, 18'sd1}},
      '{31'h7FFFFFFF,   1'b1, '{18'sd23170, 18'sd18537}},
      '{31'd2,          1'b0, '0},
      '{31'd3,          1'b0, '0},
      '{31'd4,          1'b0, '0},
      '{31'd5,          1'b0, '0},
      '{31'd6,          1'b0, '0},
      '{31'd7,          1'b0, '0},
      '{31'd8,          1'b0, '0},
      '{31'd9,          1'b0, '0},
      '{31'd12,         1'b0, '0},
      '{31'd13,         1'b0, '0},
      '{31'd16,         1'b0, '0},
      '{31'd20,         1'b0, '0},
      '{31'd21,         1'b0, '0},
      '{31'd2147395600, 1'b0, '0},
      '{31'd2147441940, 1'b0, '0},
      '{31'd2147441941, 1'b0, '0},
      '{31'd1073741824, 1'b0, '0},
      '{31'd1073741823, 1'b0, '0},
      '{31'h55555555,   1'b0, '0},
      '{31'h2AAAAAAA,   1'b0, '0}
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (index_table[i])
      send_index(index_table[i].idx, index_table[i].typed, index_table[i].pt);

    // hold off until the table has fully drained
    valid_i <= 1'b0;
    wait_for_drain();

    for (int i = 0; i < NUM_RANDOM; i++) begin
      calm_phase = ((i / 150) % 4 == 1);
      if (i == NUM_RANDOM / 2) begin
        valid_i <= 1'b0;
        wait_for_drain();
      end
      send_index(random_index(), 1'b0, none_pt);
    end
    valid_i <= 1'b0;
    calm_phase = 1'b0;

    wait_for_drain();
    repeat (2 * LATENCY) @(posedge clk_i);

    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/ssxy_pkg.sv
hw/rtl/ssxy_front.sv
hw/rtl/ssxy_queue.sv
hw/rtl/ssxy_back.sv
hw/rtl/square_spiral_index_to_xy_core.sv
hw/rtl/ssxy_chk.sv
dv/tb_square_spiral_index_to_xy_core.sv
